// ===== rtl/pcfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcfl_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
  // A head or link holds frame + 1, with zero as the end-of-list marker.
  localparam int LINK_W     = FRAME_W + 1;
  localparam int CPU_ID_W   = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/pcfl_page_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcfl_page_index #(
  parameter int PAGE_COUNT = 32768
) (
  input  wire logic [pcfl_pkg::ADDR_W-1:0]  low_limit,
  input  wire logic [pcfl_pkg::FRAME_W-1:0] frame,
  output logic                              in_range,
  output logic [((PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1)-1:0] index
);

  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LW = pcfl_pkg::LINK_W;
  localparam logic [LW-1:0] PAGE_LIMIT = LW'(PAGE_COUNT);
  localparam logic [pcfl_pkg::ADDR_W:0] PAGE_MASK =
    (pcfl_pkg::ADDR_W+1)'((1 << pcfl_pkg::PAGE_SHIFT) - 1);

  logic [pcfl_pkg::ADDR_W:0] low_round;
  logic [LW-1:0]             base;
  logic [LW:0]               diff;

  // The base frame is the lower limit rounded up to a page boundary.
  assign low_round = {1'b0, low_limit} + PAGE_MASK;
  assign base      = low_round[pcfl_pkg::ADDR_W:pcfl_pkg::PAGE_SHIFT];
  assign diff      = {2'b00, frame} - {1'b0, base};
  // A borrow means the frame lies below the base, which wraps to a huge index.
  assign in_range  = !diff[LW] && (diff[LW-1:0] < PAGE_LIMIT);
  assign index     = diff[PW-1:0];

endmodule

`default_nettype wire

// ===== rtl/per_cpu_page_free_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-CPU page free list allocator.
// Requests enter on the s_ stream: s_tuser is the operation (0 allocate,
// 1 free) and s_tdata carries the CPU number and the page address. Each
// request gives exactly one result on the m_ stream: m_tuser is the status
// (0 ok, 1 out of memory, 2 bad address) and m_tdata the granted address.
// The limits are to be written through cfg_we/cfg_index/cfg_data by the user
// only while idle; the block does not enforce it. The chosen list's head is
// read on acceptance. A free checks the address and, once the output register
// is free, registers its result and, for a good address, writes the link and
// head memories. An allocate reads the popped page's next link in the
// following cycle, then, likewise, writes the head back and registers its
// result; with every list empty it skips the link read and the head write.
// The next request is accepted in the cycle after the result is registered,
// so a result may wait there while the following request is being worked on.
// If the receiver stalls with a result still held, the final cycle of the
// next request waits until the output register frees up.
// Reset empties all lists at once through per-CPU valid bits; the link
// memory needs no clearing pass, and the limits return to their defaults.
module per_cpu_page_free_list #(
  parameter int CPU_COUNT  = 8,
  parameter int PAGE_COUNT = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // cpu_id [2:0], page_address [34:3], zero fill
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // granted_address [31:0]
  output logic [1:0]       m_tuser,   // status
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LW = pcfl_pkg::LINK_W;
  localparam int FW = pcfl_pkg::FRAME_W;
  localparam int AW = pcfl_pkg::ADDR_W;
  localparam int SH = pcfl_pkg::PAGE_SHIFT;
  localparam logic CFG_LOW = 1'b0;
  localparam logic CFG_TOP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FREE = 4'b0010,
    S_LOOK = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] low_limit, top_limit;

  logic [LW-1:0]        head_mem [CPU_COUNT];
  logic [LW-1:0]        link_mem [PAGE_COUNT];
  logic [CPU_COUNT-1:0] nonempty;

  logic [LW-1:0] head_q;
  logic          head_ok;
  logic [LW-1:0] link_q;
  logic          link_ok;

  logic [CW-1:0] cpu_q;
  logic [CW-1:0] target;
  logic          found;
  logic [AW-1:0] addr_q;

  logic [CW-1:0] cpu_sel;
  logic [CW-1:0] lowest;
  logic [CW-1:0] rd_cpu;
  logic          accept;
  logic          out_free;

  logic [FW-1:0] idx_frame;
  logic [FW-1:0] head_frame;
  logic          idx_in_range;
  logic [PW-1:0] idx;
  logic          free_bad;
  logic [LW-1:0] pop_next;

  logic          head_we;
  logic [CW-1:0] head_wa;
  logic [LW-1:0] head_wd;
  logic          link_we;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= 32'h8000_0000;
      top_limit <= 32'h8800_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW: low_limit <= cfg_data;
        CFG_TOP: top_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // CPU number folded into the configured CPU count.
  always_comb begin
    cpu_sel = '0;
    for (int v = 0; v < 8; v++) begin
      if (s_tdata[2:0] == 3'(v)) begin
        cpu_sel = CW'(v % CPU_COUNT);
      end
    end
  end

  always_comb begin
    lowest = '0;
    for (int c = CPU_COUNT - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        lowest = CW'(c);
      end
    end
  end

  // An allocate steals from the lowest non-empty list only when its own is empty.
  always_comb begin
    if (s_tuser == pcfl_pkg::OP_FREE || nonempty[cpu_sel]) begin
      rd_cpu = cpu_sel;
    end else begin
      rd_cpu = lowest;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign head_frame = FW'(head_q - LW'(1));
  assign idx_frame  = (state == S_FREE) ? addr_q[AW-1:SH] : head_frame;

  pcfl_page_index #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_index (
    .low_limit (low_limit),
    .frame     (idx_frame),
    .in_range  (idx_in_range),
    .index     (idx)
  );

  assign free_bad = (addr_q[SH-1:0] != '0) || (addr_q < low_limit) ||
                    (addr_q >= top_limit) || !idx_in_range;
  assign pop_next = link_ok ? link_q : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == pcfl_pkg::OP_FREE) begin
            state_next = S_FREE;
          end else if (|nonempty) begin
            state_next = S_LOOK;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_FREE: begin
        if (out_free) state_next = S_IDLE;
      end
      S_LOOK: state_next = S_POP;
      S_POP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and head read.
  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_q   <= cpu_sel;
      target  <= rd_cpu;
      found   <= |nonempty;
      addr_q  <= s_tdata[34:3];
      head_q  <= head_mem[rd_cpu];
      head_ok <= nonempty[rd_cpu];
    end
  end

  // Next-link read of the page being popped.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      link_q  <= link_mem[idx];
      link_ok <= idx_in_range;
    end
  end

  always_comb begin
    head_we = 1'b0;
    head_wa = cpu_q;
    head_wd = '0;
    link_we = 1'b0;
    if (state == S_FREE && out_free && !free_bad) begin
      head_we = 1'b1;
      head_wd = {1'b0, addr_q[AW-1:SH]} + LW'(1);
      link_we = 1'b1;
    end else if (state == S_POP && out_free && found) begin
      head_we = 1'b1;
      head_wa = target;
      head_wd = pop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[idx] <= head_ok ? head_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (head_we) begin
      nonempty[head_wa] <= (head_wd != '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FREE || state == S_POP) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FREE && out_free) begin
      m_tuser <= free_bad ? pcfl_pkg::ST_BAD : pcfl_pkg::ST_OK;
      m_tdata <= '0;
    end else if (state == S_POP && out_free) begin
      if (found) begin
        m_tuser <= pcfl_pkg::ST_OK;
        m_tdata <= {head_frame, {SH{1'b0}}};
      end else begin
        m_tuser <= pcfl_pkg::ST_OOM;
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pcfl_pkg::*;

  localparam int CPU_COUNT      = 8;
  localparam int PAGE_COUNT     = 32768;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 130;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_MAX       = 256;

  localparam logic REG_LOW_LIMIT = 1'b0;
  localparam logic REG_TOP_LIMIT = 1'b1;

  localparam logic [31:0] PHASE_LOW [PHASE_COUNT] = '{
    32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h4000_0123, 32'h4000_0123, 32'hF800_0000, 32'h1234_5000,
    32'h1234_5000, 32'h7FFF_F001, 32'h8000_0000, 32'h0000_1000
  };
  localparam logic [31:0] PHASE_TOP [PHASE_COUNT] = '{
    32'h8800_0000, 32'hFFFF_FFFF, 32'h0040_0000, 32'hFFFF_FFFF,
    32'h4080_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1A34_5000,
    32'h1A34_6000, 32'h8800_0000, 32'h8800_0000, 32'h0000_9000
  };

  typedef struct {
    status_t     status;
    logic [31:0] granted;
  } reply_t;

  typedef struct {
    op_t         op;
    logic [2:0]  cpu;
    logic [31:0] addr;
    bit          typed;
    status_t     status;
    logic [31:0] granted;
  } request_row_t;

  // Directed requests at the reset limits. Rows with typed = 0 rely on the predictor.
  request_row_t directed_rows [23] = '{
    '{OP_ALLOC, 3'd0, 32'hDEAD_BEEF, 1'b1, ST_OOM, 32'h0},
    '{OP_FREE,  3'd0, 32'h8000_0000, 1'b1, ST_OK,  32'h0},
    '{OP_FREE,  3'd1, 32'h87FF_F000, 1'b1, ST_OK,  32'h0},
    '{OP_FREE,  3'd2, 32'h8800_0000, 1'b1, ST_BAD, 32'h0},
    '{OP_FREE,  3'd3, 32'h7FFF_F000, 1'b1, ST_BAD, 32'h0},
    '{OP_FREE,  3'd4, 32'h8000_0800, 1'b1, ST_BAD, 32'h0},
    '{OP_FREE,  3'd5, 32'hFFFF_FFFF, 1'b1, ST_BAD, 32'h0},
    '{OP_FREE,  3'd6, 32'h0000_0000, 1'b1, ST_BAD, 32'h0},
    '{OP_ALLOC, 3'd1, 32'hFFFF_FFFF, 1'b1, ST_OK,  32'h87FF_F000},
    '{OP_ALLOC, 3'd5, 32'h0000_0000, 1'b1, ST_OK,  32'h8000_0000},
    '{OP_ALLOC, 3'd3, 32'h5555_5555, 1'b1, ST_OOM, 32'h0},
    '{OP_FREE,  3'd7, 32'h8000_1000, 1'b1, ST_OK,  32'h0},
    '{OP_FREE,  3'd7, 32'h8000_2000, 1'b1, ST_OK,  32'h0},
    '{OP_FREE,  3'd2, 32'h8000_5000, 1'b1, ST_OK,  32'h0},
    '{OP_ALLOC, 3'd7, 32'hAAAA_AAAA, 1'b1, ST_OK,  32'h8000_2000},
    '{OP_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_OK,  32'h8000_5000},
    '{OP_ALLOC, 3'd7, 32'h0000_0000, 1'b1, ST_OK,  32'h8000_1000},
    '{OP_FREE,  3'd6, 32'h8001_0000, 1'b0, ST_OK,  32'h0},
    '{OP_FREE,  3'd6, 32'h8001_0000, 1'b0, ST_OK,  32'h0},
    '{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, ST_OK,  32'h0},
    '{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, ST_OK,  32'h0},
    '{OP_FREE,  3'd3, 32'h8002_0000, 1'b0, ST_OK,  32'h0},
    '{OP_ALLOC, 3'd4, 32'h0000_0000, 1'b0, ST_OK,  32'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // cpu_id [2:0], page_address [34:3], zero fill
  logic        s_tuser = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // granted_address [31:0]
  logic [1:0]  m_tuser;        // status
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  // Allocator state as the testbench sees it.
  logic [31:0]       free_floor   = 32'h8000_0000;
  logic [31:0]       free_ceiling = 32'h8800_0000;
  logic [LINK_W-1:0] cpu_head [CPU_COUNT];
  logic [LINK_W-1:0] page_link [PAGE_COUNT];
  bit                link_valid [PAGE_COUNT];

  reply_t      replies_due [$];
  logic [31:0] granted_pool [$];
  int          error_count = 0;
  int          stall_cycles = 0;
  int          tx_idle_pct = 19;
  int          rx_idle_pct = 64;

  per_cpu_page_free_list #(
    .CPU_COUNT (CPU_COUNT),
    .PAGE_COUNT(PAGE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    foreach (cpu_head[c]) cpu_head[c] = '0;
  end

  // First page frame of the window; the floor is rounded up to a page boundary.
  function automatic logic [LINK_W-1:0] window_base();
    logic [32:0] rounded;
    rounded = {1'b0, free_floor} + 33'h0FFF;
    return rounded[32:PAGE_SHIFT];
  endfunction

  function automatic logic [31:0] window_index(input logic [LINK_W-1:0] frame);
    return 32'(frame) - 32'(window_base());
  endfunction

  // Pops one list and returns its old head (frame + 1), or zero when empty.
  function automatic logic [LINK_W-1:0] take_head(input int c);
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] after;
    logic [31:0]       idx;
    head  = cpu_head[c];
    after = '0;
    if (head == '0) return '0;
    idx = window_index(head - 1'b1);
    if (idx < PAGE_COUNT) after = page_link[idx[14:0]];
    cpu_head[c] = after;
    return head;
  endfunction

  function automatic reply_t compute_reply(input op_t op, input logic [2:0] cpu,
                                           input logic [31:0] addr);
    reply_t            r;
    logic [LINK_W-1:0] frame;
    logic [LINK_W-1:0] got;
    logic [31:0]       idx;
    r.granted = '0;
    if (op == OP_FREE) begin
      frame = {1'b0, addr[31:PAGE_SHIFT]};
      idx   = window_index(frame);
      if (addr[PAGE_SHIFT-1:0] != '0 || addr < free_floor || addr >= free_ceiling ||
          idx >= PAGE_COUNT) begin
        r.status = ST_BAD;
      end else begin
        page_link[idx[14:0]]  = cpu_head[cpu];
        link_valid[idx[14:0]] = 1'b1;
        cpu_head[cpu]         = frame + 1'b1;
        r.status              = ST_OK;
      end
    end else begin
      got = take_head(int'(cpu));
      for (int i = 0; i < CPU_COUNT && got == '0; i++) begin
        if (i != int'(cpu)) got = take_head(i);
      end
      if (got == '0) begin
        r.status = ST_OOM;
      end else begin
        frame     = got - 1'b1;
        r.status  = ST_OK;
        r.granted = {frame[FRAME_W-1:0], {PAGE_SHIFT{1'b0}}};
      end
    end
    return r;
  endfunction

  // An allocate must never follow a head into a link entry that no free has written.
  function automatic bit alloc_reads_unwritten(input logic [2:0] cpu);
    logic [LINK_W-1:0] head;
    logic [31:0]       idx;
    head = cpu_head[cpu];
    for (int i = 0; i < CPU_COUNT && head == '0; i++) begin
      if (i != int'(cpu)) head = cpu_head[i];
    end
    if (head == '0) return 1'b0;
    idx = window_index(head - 1'b1);
    return idx < PAGE_COUNT && !link_valid[idx[14:0]];
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_request(input op_t op, input logic [2:0] cpu, input logic [31:0] addr,
                              input bit typed, input reply_t typed_reply);
    reply_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, addr, cpu};
    do @(posedge clk); while (!s_tready);
    predicted = compute_reply(op, cpu, addr);
    if (op == OP_ALLOC && predicted.status == ST_OK && granted_pool.size() < POOL_MAX)
      granted_pool.push_back(predicted.granted);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic program_limits(input logic [31:0] floor_val, input logic [31:0] ceil_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_LIMIT;
    cfg_data  <= floor_val;
    @(posedge clk);
    cfg_index <= REG_TOP_LIMIT;
    cfg_data  <= ceil_val;
    @(posedge clk);
    cfg_we       <= 1'b0;
    free_floor   = floor_val;
    free_ceiling = ceil_val;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d address %h",
                                  m_tuser, m_tdata));
      end else begin
        want = replies_due.pop_front();
        if (m_tuser != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
        if (m_tdata != want.granted)
          report_mismatch($sformatf("granted address %h, expected %h", m_tdata,
                                    want.granted));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    reply_t      fixed;
    op_t         op;
    logic [2:0]  cpu;
    logic [31:0] addr;
    logic [31:0] offset;
    int          free_cpu_hi;
    int          pick;
    int          slot;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      fixed.status  = directed_rows[r].status;
      fixed.granted = directed_rows[r].granted;
      send_request(directed_rows[r].op, directed_rows[r].cpu, directed_rows[r].addr,
                   directed_rows[r].typed, fixed);
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // Limits change only with the block idle: stop sending and let every result drain.
      s_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      program_limits(PHASE_LOW[phase], PHASE_TOP[phase]);

      tx_idle_pct = (phase < 4) ? 19 : (phase < 8) ? 64 : 0;
      rx_idle_pct = (phase < 4) ? 64 : (phase < 8) ? 19 : 0;
      // Most frees go to a subset of CPUs so that the others have to steal.
      free_cpu_hi = $urandom_range(0, CPU_COUNT - 1);

      repeat (PHASE_ITEMS) begin
        addr = $urandom;
        if ($urandom_range(0, 99) < 45) begin
          op  = OP_ALLOC;
          cpu = 3'($urandom_range(0, CPU_COUNT - 1));
          if (alloc_reads_unwritten(cpu)) op = OP_FREE;
        end else begin
          op   = OP_FREE;
          cpu  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, CPU_COUNT - 1))
                                             : 3'($urandom_range(0, free_cpu_hi));
          pick = $urandom_range(0, 99);
          if (pick < 40 && granted_pool.size() != 0) begin
            slot = $urandom_range(0, granted_pool.size() - 1);
            addr = granted_pool[slot];
            granted_pool.delete(slot);
          end else if (pick < 90) begin
            offset = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGE_COUNT - 1)
                                                 : $urandom_range(0, 255);
            addr = (32'(window_base()) + offset) << PAGE_SHIFT;
            if (pick >= 80) addr[PAGE_SHIFT-1:0] = 12'($urandom_range(1, 4095));
          end
        end
        fixed.status  = ST_OK;
        fixed.granted = '0;
        send_request(op, cpu, addr, 1'b0, fixed);
      end
    end

    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
